// File: design/rrva_pkg.sv
// Shared types and constants for the round-robin voice allocator.
// No dependencies; imported by every module of the block.
package rrva_pkg;

	localparam int MAX_SOUNDS_DEF = 4;
	localparam int VOICES_DEF     = 8;

	localparam int RATE_W  = 18;
	localparam int SOUND_W = 2;
	localparam int VOICE_W = 3;
	localparam int COUNT_W = 3;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_STEAL_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SOUNDS_IN_USE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_MIN      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_MAX      = 2'd3;

	localparam logic [COUNT_W-1:0] SOUNDS_IN_USE_RST = 3'd3;
	localparam logic [RATE_W-1:0]  RATE_MIN_RST      = 18'd62259;  // 0.95
	localparam logic [RATE_W-1:0]  RATE_MAX_RST      = 18'd68813;  // 1.05

	typedef enum logic {
		OP_PLAY = 1'b0,
		OP_DONE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_GRANTED  = 2'd0,
		ST_BAD_IDX  = 2'd1,
		ST_ALL_BUSY = 2'd2,
		ST_DONE_ACK = 2'd3
	} status_t;

endpackage

// File: design/rrva_row_search.sv
// Finds the first idle voice in one sound's busy row, starting at the row pointer
// and wrapping. Depends on rrva_pkg.
module rrva_row_search import rrva_pkg::*; #(
	parameter int VOICES_PER_SOUND = VOICES_DEF,
	parameter int VW = (VOICES_PER_SOUND > 1) ? $clog2(VOICES_PER_SOUND) : 1
) (
	input  logic [VOICES_PER_SOUND-1:0] busy,
	input  logic [VW-1:0]               start,
	output logic                        found,
	output logic [VW-1:0]               voice
);

	logic [2*VOICES_PER_SOUND-1:0] dbl;
	logic [VOICES_PER_SOUND-1:0]   rot;
	logic [VW-1:0]                 offset;
	logic [VW:0]                   sum;

	always_comb begin
		// rotate so the pointed voice sits at bit 0
		dbl = {busy, busy} >> start;
		rot = dbl[VOICES_PER_SOUND-1:0];
		found = 1'b0;
		offset = '0;
		for (int j = VOICES_PER_SOUND - 1; j >= 0; j--) begin
			if (!rot[j]) begin
				found = 1'b1;
				offset = VW'(j);
			end
		end
		sum = {1'b0, start} + {1'b0, offset};
		if (32'(sum) >= VOICES_PER_SOUND) begin
			sum = sum - (VW+1)'(VOICES_PER_SOUND);
		end
		voice = sum[VW-1:0];
	end

endmodule

// File: design/round_robin_voice_allocator_unit.sv
// Top level of the round-robin voice allocator: config registers, sound row
// memory, control sequencer and output register. Depends on rrva_pkg, rrva_row_search.
//
//   port group  direction  handshake           contents
//   in_*        in         in_valid/in_stall   operation, sound_number, voice_number,
//                                              rate_request
//   out_*       out        out_valid/out_stall status, granted_sound, granted_voice,
//                                              voice_restarted, rate_out
//   cfg_*       in         cfg_write           cfg_index, cfg_data
//
// One transaction at a time: accept, read the sound row, evaluate.
// Steal, done and bad-index transactions read one row; a search reads and evaluates
// sound rows one after another, visiting at most sounds_in_use of them.
// Each visited sound needs its own read of the single-port row memory.
// A new transaction is accepted while the previous result waits at the output.
// Row state reads as zero after reset through per-row valid flops; no clearing pass.
module round_robin_voice_allocator_unit import rrva_pkg::*; #(
	parameter int MAX_SOUNDS       = MAX_SOUNDS_DEF,
	parameter int VOICES_PER_SOUND = VOICES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [RATE_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 operation,
	input  logic [SOUND_W-1:0]   sound_number,
	input  logic [VOICE_W-1:0]   voice_number,
	input  logic [RATE_W-1:0]    rate_request,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status,
	output logic [SOUND_W-1:0]   granted_sound,
	output logic [VOICE_W-1:0]   granted_voice,
	output logic                 voice_restarted,
	output logic [RATE_W-1:0]    rate_out
);

	localparam int SW = (MAX_SOUNDS > 1) ? $clog2(MAX_SOUNDS) : 1;
	localparam int NW = $clog2(MAX_SOUNDS + 1);
	localparam int VW = (VOICES_PER_SOUND > 1) ? $clog2(VOICES_PER_SOUND) : 1;
	localparam int RW = VW + VOICES_PER_SOUND;
	localparam logic [VOICES_PER_SOUND-1:0] BIT0 = VOICES_PER_SOUND'(1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_EVAL
	} state_t;

	state_t state_q;

	// config registers
	logic              steal_mode_q;
	logic [COUNT_W-1:0] sounds_in_use_q;
	logic [RATE_W-1:0] rate_min_q;
	logic [RATE_W-1:0] rate_max_q;

	// transaction registers
	op_t               op_q;
	logic              bad_q;
	logic              done_ok_q;
	logic [SW-1:0]     snd_q;
	logic [VW-1:0]     vce_q;
	logic [RATE_W-1:0] req_q;
	logic [NW-1:0]     n_q;
	logic [NW-1:0]     k_q;

	// row memory: {pointer, busy bits} per sound
	logic [RW-1:0]         row_mem [MAX_SOUNDS];
	logic [MAX_SOUNDS-1:0] row_vld_q;
	logic [RW-1:0]         rd_q;
	logic                  rdv_q;

	// output register
	logic              out_valid_q;
	status_t           status_q;
	logic [SOUND_W-1:0] gsound_q;
	logic [VOICE_W-1:0] gvoice_q;
	logic              restart_q;
	logic [RATE_W-1:0] rate_q;

	logic [NW-1:0]     n_cur;
	logic              snd_in_range;
	logic              accept;

	logic [VOICES_PER_SOUND-1:0] row_busy;
	logic [VW-1:0]     row_ptr;
	logic              srch_found;
	logic [VW-1:0]     srch_voice;
	logic [VW-1:0]     sel_voice;
	logic [VW-1:0]     next_ptr;
	logic [VOICES_PER_SOUND-1:0] sel_bit;
	logic [RATE_W-1:0] rate_lo;
	logic [RATE_W-1:0] rate_clamped;
	logic              out_free;
	logic              emit;
	logic              go_next;
	logic              wr_en;
	logic [RW-1:0]     wr_data;
	status_t           res_status;
	logic              res_grant;
	logic              res_restart;
	logic [SW-1:0]     snd_next;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		if (32'(sounds_in_use_q) > MAX_SOUNDS) begin
			n_cur = NW'(MAX_SOUNDS);
		end else begin
			n_cur = NW'(sounds_in_use_q);
		end
		snd_in_range = 32'(sound_number) < MAX_SOUNDS;
	end

	assign row_busy = rdv_q ? rd_q[VOICES_PER_SOUND-1:0] : '0;
	assign row_ptr  = rdv_q ? rd_q[RW-1:VOICES_PER_SOUND] : '0;

	rrva_row_search #(
		.VOICES_PER_SOUND(VOICES_PER_SOUND),
		.VW(VW)
	) u_search (
		.busy (row_busy),
		.start(row_ptr),
		.found(srch_found),
		.voice(srch_voice)
	);

	always_comb begin
		sel_voice = steal_mode_q ? row_ptr : srch_voice;
		sel_bit   = BIT0 << sel_voice;
		if (32'(sel_voice) + 1 == VOICES_PER_SOUND) begin
			next_ptr = '0;
		end else begin
			next_ptr = sel_voice + VW'(1);
		end
		rate_lo      = (req_q < rate_min_q) ? rate_min_q : req_q;
		rate_clamped = (rate_lo > rate_max_q) ? rate_max_q : rate_lo;
		if (32'(snd_q) + 1 == 32'(n_q)) begin
			snd_next = '0;
		end else begin
			snd_next = snd_q + SW'(1);
		end
	end

	// evaluation of the row just read
	always_comb begin
		emit        = 1'b0;
		go_next     = 1'b0;
		wr_en       = 1'b0;
		wr_data     = {row_ptr, row_busy};
		res_status  = ST_GRANTED;
		res_grant   = 1'b0;
		res_restart = 1'b0;
		if (state_q == S_EVAL) begin
			priority if (op_q == OP_DONE) begin
				emit       = out_free;
				wr_en      = out_free && done_ok_q;
				wr_data    = {row_ptr, row_busy & ~(BIT0 << vce_q)};
				res_status = ST_DONE_ACK;
			end else if (bad_q) begin
				emit       = out_free;
				res_status = ST_BAD_IDX;
			end else if (steal_mode_q || srch_found) begin
				emit        = out_free;
				wr_en       = out_free;
				wr_data     = {next_ptr, row_busy | sel_bit};
				res_grant   = 1'b1;
				res_restart = steal_mode_q && ((row_busy & sel_bit) != '0);
			end else if (32'(k_q) + 1 == 32'(n_q)) begin
				emit       = out_free;
				res_status = ST_ALL_BUSY;
			end else begin
				go_next = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			row_mem[snd_q] <= wr_data;
		end
		if (state_q == S_READ) begin
			rd_q <= row_mem[snd_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			steal_mode_q    <= 1'b0;
			sounds_in_use_q <= SOUNDS_IN_USE_RST;
			rate_min_q      <= RATE_MIN_RST;
			rate_max_q      <= RATE_MAX_RST;
			row_vld_q       <= '0;
			rdv_q           <= 1'b0;
			op_q            <= OP_PLAY;
			bad_q           <= 1'b0;
			done_ok_q       <= 1'b0;
			snd_q           <= '0;
			vce_q           <= '0;
			req_q           <= '0;
			n_q             <= '0;
			k_q             <= '0;
			out_valid_q     <= 1'b0;
			status_q        <= ST_GRANTED;
			gsound_q        <= '0;
			gvoice_q        <= '0;
			restart_q       <= 1'b0;
			rate_q          <= '0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					CFG_STEAL_MODE:    steal_mode_q    <= cfg_data[0];
					CFG_SOUNDS_IN_USE: sounds_in_use_q <= cfg_data[COUNT_W-1:0];
					CFG_RATE_MIN:      rate_min_q      <= cfg_data;
					CFG_RATE_MAX:      rate_max_q      <= cfg_data;
					default: ;
				endcase
			end

			// a new result replaces the one leaving in the same cycle
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (wr_en) begin
				row_vld_q[snd_q] <= 1'b1;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q      <= op_t'(operation);
						snd_q     <= snd_in_range ? SW'(sound_number) : '0;
						vce_q     <= VW'(voice_number);
						req_q     <= rate_request;
						n_q       <= n_cur;
						k_q       <= '0;
						bad_q     <= 32'(sound_number) >= 32'(n_cur);
						done_ok_q <= snd_in_range && (32'(voice_number) < VOICES_PER_SOUND);
						state_q   <= S_READ;
					end
				end
				S_READ: begin
					rdv_q   <= row_vld_q[snd_q];
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (go_next) begin
						snd_q   <= snd_next;
						k_q     <= k_q + NW'(1);
						state_q <= S_READ;
					end else if (emit) begin
						status_q    <= res_status;
						gsound_q    <= res_grant ? SOUND_W'(snd_q) : '0;
						gvoice_q    <= res_grant ? VOICE_W'(sel_voice) : '0;
						restart_q   <= res_restart;
						rate_q      <= res_grant ? rate_clamped : '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign granted_sound   = gsound_q;
	assign granted_voice   = gvoice_q;
	assign voice_restarted = restart_q;
	assign rate_out        = rate_q;

endmodule
